FILE: hdl/vpbd_pkg.sv
// ----------------------------------------------------------------------------
// vpbd_pkg: shared definitions of the VAN pulse-to-byte deframer
// Constants, register indexes, the sequencer state type and the result type.
// ----------------------------------------------------------------------------
`default_nettype none

package vpbd_pkg;

  localparam int unsigned MaxFrameBytes = 32;
  localparam int unsigned CountW        = 6;
  localparam int unsigned IndexW        = 5;
  localparam int unsigned DurW          = 8;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned CfgDataW      = 8;

  localparam logic [3:0] ManchesterPos = 4'd4;
  localparam logic [3:0] EndOfGroupPos = 4'd9;
  localparam logic [3:0] BitsPerByte   = 4'd8;
  // With fewer remaining slices than this, no further byte can complete.
  localparam logic [DurW-1:0] GroupLen = 8'd10;

  localparam logic [CountW-1:0] MaxCount = CountW'(MaxFrameBytes);
  localparam logic [IndexW-1:0] SatIndex = IndexW'(MaxFrameBytes - 1);

  localparam logic [CfgIdxW-1:0] RegLineInverted = 1'd0;
  localparam logic [CfgIdxW-1:0] RegSliceLength  = 1'd1;

  localparam logic OpStartOfFrame = 1'b0;
  localparam logic OpPulse        = 1'b1;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StDiv   = 4'b0010,
    StRound = 4'b0100,
    StSlice = 4'b1000
  } state_e;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic [IndexW-1:0] byte_index;
    logic              overflow;
    logic              last_of_run;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/vpbd_if.sv
// ----------------------------------------------------------------------------
// vpbd_in_if / vpbd_out_if: valid/ready channels of the deframer
// The pulse channel carries opcode, level and duration; the byte channel
// carries one assembled byte with its frame position and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface vpbd_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic       level;
  logic [7:0] duration;

  modport source (output valid, output opcode, output level, output duration, input ready);
  modport sink   (input valid, input opcode, input level, input duration, output ready);
endinterface

interface vpbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [4:0] byte_index;
  logic       overflow;
  logic       last_of_run;

  modport source (output valid, output data_byte, output byte_index, output overflow,
                  output last_of_run, input ready);
  modport sink   (input valid, input data_byte, input byte_index, input overflow,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: hdl/van_pulse_to_byte_deframer.sv
// ----------------------------------------------------------------------------
// van_pulse_to_byte_deframer: VAN bus pulse-to-byte deframer
// Turns measured line pulses into frame bytes (enhanced Manchester, no CRC).
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one transaction per pulse capture: opcode (start of frame or
//   pulse), line level and duration in ticks. A start-of-frame transaction
//   clears the frame state in the cycle it is taken and keeps in_i ready.
//   out_o carries one transaction per completed byte; last_of_run marks the
//   last byte that a pulse produced.
//   A pulse first passes a shift/subtract unit that divides the duration
//   by the slice length; the quotient is then rounded, the slice loop takes
//   one time slice of the pulse per cycle (n slices, up to 255) unless it
//   waits at a byte boundary, and the sequencer returns to idle. in_i is not
//   ready meanwhile. A byte is registered for out_o at its end-of-group slice.
//   Results sit in an output register; when the receiver stalls with a byte
//   still held, the slice loop waits at the next byte boundary.
//   Reset clears the frame state, sets line_inverted to 0 and slice_length
//   to 8, and empties the output register. Configuration writes use
//   cfg_we_i, cfg_idx_i and cfg_data_i and are taken in any cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module van_pulse_to_byte_deframer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [vpbd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [vpbd_pkg::CfgDataW-1:0] cfg_data_i,
  vpbd_in_if.sink                            in_i,
  vpbd_out_if.source                         out_o
);
  import vpbd_pkg::*;

  logic            line_inv_q;
  logic [7:0]      slice_len_q;

  state_e          state_q, state_d;
  logic [2:0]      step_q, step_d;
  logic [7:0]      rem_q, rem_d;
  logic [7:0]      quo_q, quo_d;
  logic [7:0]      dur_q, dur_d;
  logic            lvl_q, lvl_d;
  logic [7:0]      cnt_q, cnt_d;

  logic [3:0]      bitpos_q, bitpos_d;
  logic [7:0]      acc_q, acc_d;
  logic [3:0]      placed_q, placed_d;
  logic [CountW-1:0] fbc_q, fbc_d;

  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;

  // Shift/subtract unit of the divider.
  logic [8:0] trial;
  logic       trial_ge;
  logic [8:0] trial_diff;

  // Rounding.
  logic       round_up;
  logic [8:0] round_sum;

  logic       out_free;
  logic       over;

  assign trial      = {rem_q, quo_q[7]};
  assign trial_ge   = trial >= {1'b0, slice_len_q};
  assign trial_diff = trial - {1'b0, slice_len_q};

  assign round_up  = rem_q > (slice_len_q >> 1);
  assign round_sum = {1'b0, dur_q} - {1'b0, rem_q} + {1'b0, slice_len_q};

  assign out_free = !out_valid_q || out_o.ready;
  assign over     = fbc_q >= MaxCount;

  assign in_i.ready = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_inv_q  <= 1'b0;
      slice_len_q <= 8'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLineInverted: line_inv_q  <= cfg_data_i[0];
        RegSliceLength:  slice_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dur_d       = dur_q;
    lvl_d       = lvl_q;
    cnt_d       = cnt_q;
    bitpos_d    = bitpos_q;
    acc_d       = acc_q;
    placed_d    = placed_q;
    fbc_d       = fbc_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;

    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          if (in_i.opcode == OpStartOfFrame) begin
            bitpos_d = '0;
            acc_d    = '0;
            placed_d = '0;
            fbc_d    = '0;
          end else if (slice_len_q != 8'd0) begin
            state_d = StDiv;
            step_d  = '0;
            rem_d   = '0;
            quo_d   = in_i.duration;
            dur_d   = in_i.duration;
            lvl_d   = in_i.level ^ line_inv_q;
          end
        end
      end
      StDiv: begin
        // One quotient bit per cycle, restoring division.
        rem_d  = trial_ge ? trial_diff[7:0] : trial[7:0];
        quo_d  = {quo_q[6:0], trial_ge};
        step_d = step_q + 3'd1;
        if (step_q == 3'd7) begin
          state_d = StRound;
        end
      end
      StRound: begin
        // Rounding up past 255 wraps below one slice, which counts as zero.
        if (round_up) begin
          cnt_d = round_sum[8] ? 8'd0 : quo_q + 8'd1;
        end else begin
          cnt_d = quo_q;
        end
        state_d = StSlice;
      end
      StSlice: begin
        if (cnt_q == 8'd0) begin
          state_d = StIdle;
        end else if (bitpos_q == EndOfGroupPos) begin
          if (out_free) begin
            out_valid_d       = 1'b1;
            out_d.data_byte   = acc_q;
            out_d.byte_index  = over ? SatIndex : fbc_q[IndexW-1:0];
            out_d.overflow    = over;
            out_d.last_of_run = (cnt_q <= GroupLen);
            if (!over) begin
              fbc_d = fbc_q + CountW'(1);
            end
            bitpos_d = '0;
            placed_d = '0;
            acc_d    = '0;
            cnt_d    = cnt_q - 8'd1;
          end
        end else begin
          if (bitpos_q != ManchesterPos && placed_q < BitsPerByte) begin
            if (lvl_q) begin
              acc_d = acc_q | (8'h80 >> placed_q[2:0]);
            end
            placed_d = placed_q + 4'd1;
          end
          bitpos_d = bitpos_q + 4'd1;
          cnt_d    = cnt_q - 8'd1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      cnt_q       <= '0;
      bitpos_q    <= '0;
      acc_q       <= '0;
      placed_q    <= '0;
      fbc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      bitpos_q    <= bitpos_d;
      acc_q       <= acc_d;
      placed_q    <= placed_d;
      fbc_q       <= fbc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dur_q <= dur_d;
    lvl_q <= lvl_d;
    out_q <= out_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.data_byte   = out_q.data_byte;
  assign out_o.byte_index  = out_q.byte_index;
  assign out_o.overflow    = out_q.overflow;
  assign out_o.last_of_run = out_q.last_of_run;

endmodule

`default_nettype wire

FILE: hdl/vpbd_checker.sv
// ----------------------------------------------------------------------------
// vpbd_checker: port-level assertions for the deframer
// Watches the pulse and byte channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module vpbd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       in_opcode_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_data_byte_i,
  input wire logic [4:0] out_byte_index_i,
  input wire logic       out_overflow_i,
  input wire logic       out_last_of_run_i
);
  import vpbd_pkg::*;

  // A start-of-frame transaction leaves the sequencer idle, so the input
  // stays ready in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_opcode_i == OpStartOfFrame) |=> in_ready_i)
    else $error("input not ready right after a start-of-frame transaction");

  // Bytes past the frame capacity carry the saturated index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_overflow_i) |-> (out_byte_index_i == SatIndex))
    else $error("overflow byte with unsaturated index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(out_data_byte_i) && $stable(out_byte_index_i) &&
       $stable(out_overflow_i) && $stable(out_last_of_run_i)))
    else $error("result changed while stalled");

endmodule

bind van_pulse_to_byte_deframer vpbd_checker u_vpbd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_opcode_i       (in_i.opcode),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_data_byte_i   (out_o.data_byte),
  .out_byte_index_i  (out_o.byte_index),
  .out_overflow_i    (out_o.overflow),
  .out_last_of_run_i (out_o.last_of_run)
);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for van_pulse_to_byte_deframer
// Drives pulse and start-of-frame transactions with random gaps, predicts
// every assembled byte, and compares each byte transaction field by field.
// Starts with a short table of directed rows, then random frames under
// several slice lengths and line polarities.
// ----------------------------------------------------------------------------
module tb_top;
  import vpbd_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 300;
  localparam int unsigned MaxGap        = 12;
  localparam int unsigned NumRows       = 23;
  localparam int unsigned NumPhases     = 7;

  // One directed row; when count_known is set, the number of bytes that the
  // pulse must produce is given in byte_count_exp.
  typedef struct packed {
    logic       op;
    logic       lvl;
    logic [7:0] dur;
    logic       count_known;
    logic [4:0] byte_count_exp;
  } pulse_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  vpbd_in_if  pulse_if ();
  vpbd_out_if byte_if ();

  van_pulse_to_byte_deframer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (pulse_if),
    .out_o      (byte_if)
  );

  // Predictor state and configuration.
  logic       line_inv;
  logic [7:0] slice_len;
  logic [3:0] group_pos;
  logic [7:0] byte_acc;
  logic [3:0] bits_in_byte;
  logic [5:0] frame_bytes;

  result_t expected_bytes[$];
  result_t want;
  int      errors;
  int      stuck_cycles;
  int      sender_calm;
  int      receiver_calm;

  pulse_row_t directed_rows [NumRows] = '{
    '{OpStartOfFrame, 1'b0, 8'd0,   1'b1, 5'd0},
    '{OpPulse,        1'b1, 8'd0,   1'b1, 5'd0},
    '{OpPulse,        1'b0, 8'd3,   1'b1, 5'd0},
    '{OpPulse,        1'b1, 8'd4,   1'b1, 5'd0},
    '{OpPulse,        1'b1, 8'd253, 1'b1, 5'd0},
    '{OpPulse,        1'b0, 8'd255, 1'b1, 5'd0},
    '{OpPulse,        1'b1, 8'd5,   1'b0, 5'd0},
    '{OpPulse,        1'b1, 8'd252, 1'b0, 5'd0},
    '{OpPulse,        1'b0, 8'd252, 1'b0, 5'd0},
    '{OpPulse,        1'b1, 8'd252, 1'b0, 5'd0},
    '{OpPulse,        1'b0, 8'd252, 1'b0, 5'd0},
    '{OpPulse,        1'b1, 8'd252, 1'b0, 5'd0},
    '{OpPulse,        1'b0, 8'd252, 1'b0, 5'd0},
    '{OpPulse,        1'b1, 8'd252, 1'b0, 5'd0},
    '{OpPulse,        1'b0, 8'd252, 1'b0, 5'd0},
    '{OpPulse,        1'b1, 8'd252, 1'b0, 5'd0},
    '{OpPulse,        1'b0, 8'd252, 1'b0, 5'd0},
    '{OpPulse,        1'b1, 8'd252, 1'b0, 5'd0},
    '{OpPulse,        1'b0, 8'd252, 1'b0, 5'd0},
    '{OpStartOfFrame, 1'b1, 8'd255, 1'b1, 5'd0},
    '{OpPulse,        1'b0, 8'd80,  1'b1, 5'd1},
    '{OpPulse,        1'b1, 8'd160, 1'b1, 5'd2},
    '{OpStartOfFrame, 1'b1, 8'd255, 1'b1, 5'd0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Duration to number of time slices; rounding up wraps modulo 256.
  function automatic int slices_in(logic [7:0] dur, logic [7:0] slice);
    int d;
    int sl;
    int rem;
    int rounded;
    d  = dur;
    sl = slice;
    if (sl == 0) return 0;
    rem = d % sl;
    if (rem > sl / 2) rounded = (d + sl - rem) & 8'hFF;
    else rounded = d - rem;
    return rounded / sl;
  endfunction

  function automatic int draw_gap(inout int calm);
    int gap;
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, MaxGap);
      if ($urandom_range(0, 24) == 0) calm = $urandom_range(10, 30);
    end
    return gap;
  endfunction

  // Applies one accepted transaction to the predictor and queues the bytes
  // it completes. The newest byte is held back so it can be marked last.
  task automatic predict_bytes(input logic op, input logic lvl, input logic [7:0] dur,
                               output int produced);
    logic    bit_val;
    logic    over;
    int      slices;
    result_t held;
    produced = 0;
    if (op == OpStartOfFrame) begin
      group_pos    = '0;
      byte_acc     = '0;
      bits_in_byte = '0;
      frame_bytes  = '0;
      return;
    end
    bit_val = lvl ^ line_inv;
    slices  = slices_in(dur, slice_len);
    for (int i = 0; i < slices; i++) begin
      if (group_pos != ManchesterPos && group_pos != EndOfGroupPos) begin
        if (bits_in_byte < BitsPerByte) begin
          if (bit_val) byte_acc[7 - bits_in_byte] = 1'b1;
          bits_in_byte++;
        end
        group_pos++;
      end else if (group_pos == EndOfGroupPos) begin
        if (produced > 0) expected_bytes.push_back(held);
        over             = (frame_bytes >= MaxCount);
        held.data_byte   = byte_acc;
        held.byte_index  = over ? SatIndex : frame_bytes[IndexW-1:0];
        held.overflow    = over;
        held.last_of_run = 1'b0;
        produced++;
        if (!over) frame_bytes++;
        group_pos    = '0;
        bits_in_byte = '0;
        byte_acc     = '0;
      end else begin
        group_pos++;
      end
    end
    if (produced > 0) begin
      held.last_of_run = 1'b1;
      expected_bytes.push_back(held);
    end
  endtask

  // Entered just after a falling edge; returns just after a falling edge.
  // The valid line stays high when the next transaction follows at once.
  task automatic send_pulse(input logic op, input logic lvl, input logic [7:0] dur,
                            input logic count_known, input int count_exp);
    int gap;
    int produced;
    gap = draw_gap(sender_calm);
    if (gap > 0) begin
      pulse_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pulse_if.valid    = 1'b1;
    pulse_if.opcode   = op;
    pulse_if.level    = lvl;
    pulse_if.duration = dur;
    do @(posedge clk_i); while (pulse_if.ready !== 1'b1);
    predict_bytes(op, lvl, dur, produced);
    if (count_known && produced != count_exp) begin
      $display("%0t: byte count for pulse, expected %0d, actual %0d",
               $time, count_exp, produced);
      errors++;
    end
    @(negedge clk_i);
  endtask

  // Only called with the block idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    if (idx == RegLineInverted) line_inv = val[0];
    else slice_len = val;
  endtask

  // A pulse that produces no byte may still be running in the slice loop,
  // so the drain ends with a pause as long as the slowest pulse.
  task automatic drain;
    pulse_if.valid = 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Mostly well-formed frames: a start of frame followed by alternating-level
  // pulses whose durations sit near whole slice counts. The rest is noise.
  task automatic random_frames(input int items);
    int         left;
    int         pulses;
    int         kmax;
    int         k;
    int         d;
    logic       lvl;
    logic       op;
    left = items;
    while (left > 0) begin
      if ($urandom_range(0, 6) == 0) begin
        op = ($urandom_range(0, 7) == 0) ? OpStartOfFrame : OpPulse;
        send_pulse(op, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, 0);
        left--;
      end else begin
        send_pulse(OpStartOfFrame, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   1'b0, 0);
        pulses = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 10);
        // Keep the phase close to its item budget.
        if (pulses > left - 1) pulses = left - 1;
        lvl    = 1'($urandom_range(0, 1));
        for (int p = 0; p < pulses; p++) begin
          if (slice_len == 0) begin
            d = $urandom_range(0, 255);
          end else begin
            kmax = 255 / slice_len;
            if ($urandom_range(0, 3) == 0 || kmax < 5) k = $urandom_range(1, kmax);
            else k = $urandom_range(1, 5);
            d = k * slice_len;
            if ($urandom_range(0, 1) == 1) d = d + $urandom_range(0, slice_len / 2);
            else d = d - $urandom_range(0, (slice_len - 1) / 2);
            if (d > 255) d = 255;
          end
          send_pulse(OpPulse, lvl, 8'(d), 1'b0, 0);
          lvl = ~lvl;
        end
        left -= pulses + 1;
      end
    end
  endtask

  // Byte receiver with random stalls.
  initial begin
    int gap;
    byte_if.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      gap = draw_gap(receiver_calm);
      if (gap > 0) begin
        byte_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      byte_if.ready = 1'b1;
      do @(posedge clk_i); while (byte_if.valid !== 1'b1);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && byte_if.valid === 1'b1 && byte_if.ready === 1'b1) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: byte transaction with none expected, actual %h/%0d/%b/%b", $time,
                 byte_if.data_byte, byte_if.byte_index, byte_if.overflow,
                 byte_if.last_of_run);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (byte_if.data_byte !== want.data_byte) begin
          $display("%0t: data_byte expected %h, actual %h",
                   $time, want.data_byte, byte_if.data_byte);
          errors++;
        end
        if (byte_if.byte_index !== want.byte_index) begin
          $display("%0t: byte_index expected %0d, actual %0d",
                   $time, want.byte_index, byte_if.byte_index);
          errors++;
        end
        if (byte_if.overflow !== want.overflow) begin
          $display("%0t: overflow expected %b, actual %b",
                   $time, want.overflow, byte_if.overflow);
          errors++;
        end
        if (byte_if.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %b, actual %b",
                   $time, want.last_of_run, byte_if.last_of_run);
          errors++;
        end
      end
    end
  end

  // Ends the run when neither channel completes a transaction for too long.
  always @(posedge clk_i) begin
    if ((pulse_if.valid === 1'b1 && pulse_if.ready === 1'b1) ||
        (byte_if.valid === 1'b1 && byte_if.ready === 1'b1)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    logic       phase_inv   [NumPhases];
    logic [7:0] phase_slice [NumPhases];
    int         phase_items [NumPhases];
    errors            = 0;
    stuck_cycles      = 0;
    sender_calm       = 0;
    receiver_calm     = 0;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    pulse_if.valid    = 1'b0;
    pulse_if.opcode   = OpStartOfFrame;
    pulse_if.level    = 1'b0;
    pulse_if.duration = '0;
    line_inv          = 1'b0;
    slice_len         = 8'd8;
    group_pos         = '0;
    byte_acc          = '0;
    bits_in_byte      = '0;
    frame_bytes       = '0;

    phase_inv   = '{1'b1, 1'b0,   1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    phase_slice = '{8'd1, 8'd255, 8'd3, 8'd0, 8'($urandom_range(2, 254)), 8'd8, 8'd7};
    phase_items = '{60, 50, 60, 12, 60, 60, 60};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows run with the reset configuration.
    for (int r = 0; r < NumRows; r++) begin
      send_pulse(directed_rows[r].op, directed_rows[r].lvl, directed_rows[r].dur,
                 directed_rows[r].count_known, directed_rows[r].byte_count_exp);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      // Upper data bits are don't-care for the polarity register.
      write_reg(RegLineInverted, CfgDataW'(($urandom_range(0, 127) << 1) | phase_inv[ph]));
      write_reg(RegSliceLength, phase_slice[ph]);
      random_frames(phase_items[ph]);
    end

    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
